[rtl/mpu_data_access_checker_top_defines.svh]
// Assertion macros used by the MPU data access checker assertion module.
`ifndef MPU_DATA_ACCESS_CHECKER_TOP_DEFINES_SVH
`define MPU_DATA_ACCESS_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define MPU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define MPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs through reset.
`define MPU_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mpu_dac_pkg.sv]
// Types, codes and default sizes for the MPU data access checker.
package mpu_dac_pkg;

    localparam int DEF_DATA_REGIONS    = 16;
    localparam int DEF_PROTECTION_SETS = 6;
    localparam int DEF_ADDRESS_BITS    = 32;

    // Field widths of the stream words
    localparam int OP_W     = 2;
    localparam int REGION_W = 4;
    localparam int SET_W    = 3;
    localparam int FADDR_W  = 32;
    localparam int MASK_W   = 16;
    localparam int VERD_W   = 2;

    localparam int S_TUSER_W = OP_W + 1;
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 8;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [VERD_W-1:0] verdict_t;

    localparam op_t OP_BOUNDS     = 2'd0;
    localparam op_t OP_READ_MASK  = 2'd1;
    localparam op_t OP_WRITE_MASK = 2'd2;
    localparam op_t OP_CHECK      = 2'd3;

    localparam verdict_t VERDICT_DONE   = 2'd0;
    localparam verdict_t VERDICT_PERMIT = 2'd1;
    localparam verdict_t VERDICT_DENY   = 2'd2;

endpackage

[rtl/mpu_data_access_checker_top.sv]
// MPU data access checker: region bounds, per-set masks and access check.
//
//  channel   dir  fields
//  s_*       in   tuser: op, is_write   tdata: region_index .. length
//  m_*       out  tdata: verdict
//  cfg_*     in   protection_enable, single register, write only
//
// One word per cycle sustained while m_ is not stalled. An accepted word goes
// through the input register, comparators across all regions and the result
// register. Table writes take effect as the word leaves the input
// register, so later checks always see them. Reset clears the tables and both
// pipeline valids. A stall on m_ holds the result and the word behind it.
module mpu_data_access_checker_top #(
    parameter int DATA_REGIONS    = mpu_dac_pkg::DEF_DATA_REGIONS,
    parameter int PROTECTION_SETS = mpu_dac_pkg::DEF_PROTECTION_SETS,
    parameter int ADDRESS_BITS    = mpu_dac_pkg::DEF_ADDRESS_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [3:0] region_index, [6:4] prot_set, [38:7] lower_bound,
    // [70:39] upper_bound, [86:71] enable_mask, [118:87] address,
    // [150:119] length, [151] zero
    input  logic [mpu_dac_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] op, [2] is_write
    input  logic [mpu_dac_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] verdict, [7:2] zero
    output logic [mpu_dac_pkg::M_TDATA_W-1:0] m_tdata
);
    import mpu_dac_pkg::*;

    localparam int ADDR_W = ADDRESS_BITS;

    // configuration
    logic prot_en_reg;

    // input register
    logic                s1_valid_reg;
    op_t                 s1_op_reg;
    logic                s1_is_write_reg;
    logic [REGION_W-1:0] s1_region_reg;
    logic [SET_W-1:0]    s1_set_reg;
    logic [FADDR_W-1:0]  s1_lower_reg;
    logic [FADDR_W-1:0]  s1_upper_reg;
    logic [MASK_W-1:0]   s1_mask_reg;
    logic [FADDR_W-1:0]  s1_address_reg;
    logic [FADDR_W-1:0]  s1_length_reg;

    // tables
    logic [ADDR_W-1:0]       lower_reg [DATA_REGIONS];
    logic [ADDR_W-1:0]       upper_reg [DATA_REGIONS];
    logic [DATA_REGIONS-1:0] rd_mask_reg [PROTECTION_SETS];
    logic [DATA_REGIONS-1:0] wr_mask_reg [PROTECTION_SETS];

    // result register
    logic     out_valid_reg;
    verdict_t verdict_reg;
    verdict_t verdict_next;

    logic                    out_adv;
    logic                    s1_fire;
    logic [ADDR_W-1:0]       acc_start;
    logic [ADDR_W-1:0]       size;
    logic [ADDR_W-1:0]       acc_end;
    logic [DATA_REGIONS-1:0] enabled;
    logic                    hit;

    assign out_adv  = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && out_adv;
    assign s_tready = !s1_valid_reg || out_adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - VERD_W){1'b0}}, verdict_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prot_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            prot_en_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            s1_op_reg       <= s_tuser[OP_W-1:0];
            s1_is_write_reg <= s_tuser[OP_W];
            s1_region_reg   <= s_tdata[3:0];
            s1_set_reg      <= s_tdata[6:4];
            s1_lower_reg    <= s_tdata[38:7];
            s1_upper_reg    <= s_tdata[70:39];
            s1_mask_reg     <= s_tdata[86:71];
            s1_address_reg  <= s_tdata[118:87];
            s1_length_reg   <= s_tdata[150:119];
        end
    end

    // table writes, applied as the word moves on to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < DATA_REGIONS; r++) begin
                lower_reg[r] <= '0;
                upper_reg[r] <= '0;
            end
            for (int p = 0; p < PROTECTION_SETS; p++) begin
                rd_mask_reg[p] <= '0;
                wr_mask_reg[p] <= '0;
            end
        end else if (s1_fire) begin
            for (int r = 0; r < DATA_REGIONS; r++) begin
                if (s1_op_reg == OP_BOUNDS && 32'(s1_region_reg) == r) begin
                    lower_reg[r] <= ADDR_W'(s1_lower_reg);
                    upper_reg[r] <= ADDR_W'(s1_upper_reg);
                end
            end
            for (int p = 0; p < PROTECTION_SETS; p++) begin
                if (32'(s1_set_reg) == p) begin
                    if (s1_op_reg == OP_READ_MASK) begin
                        rd_mask_reg[p] <= DATA_REGIONS'(s1_mask_reg);
                    end
                    if (s1_op_reg == OP_WRITE_MASK) begin
                        wr_mask_reg[p] <= DATA_REGIONS'(s1_mask_reg);
                    end
                end
            end
        end
    end

    // range check against every region in parallel
    always_comb begin
        acc_start = ADDR_W'(s1_address_reg);
        size      = ADDR_W'(s1_length_reg);
        acc_end   = acc_start + size;
        // a set beyond the table leaves the mask empty
        enabled   = '0;
        for (int p = 0; p < PROTECTION_SETS; p++) begin
            if (32'(s1_set_reg) == p) begin
                enabled = s1_is_write_reg ? wr_mask_reg[p] : rd_mask_reg[p];
            end
        end
        hit = 1'b0;
        for (int r = 0; r < DATA_REGIONS; r++) begin
            if (enabled[r] && lower_reg[r] != upper_reg[r] &&
                acc_start >= lower_reg[r] && acc_end <= upper_reg[r]) begin
                hit = 1'b1;
            end
        end
    end

    always_comb begin
        priority if (s1_op_reg != OP_CHECK) begin
            verdict_next = VERDICT_DONE;
        end else if (!prot_en_reg) begin
            verdict_next = VERDICT_PERMIT;
        end else if (size == '0) begin
            verdict_next = VERDICT_PERMIT;
        end else if (acc_end < acc_start) begin
            // wrapped, including an end exactly at the top of the space
            verdict_next = VERDICT_DENY;
        end else begin
            verdict_next = hit ? VERDICT_PERMIT : VERDICT_DENY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            verdict_reg <= verdict_next;
        end
    end

endmodule

[rtl/mpu_dac_checker.sv]
// Port-level assertions for the MPU data access checker, bound to the top.
`include "mpu_data_access_checker_top_defines.svh"

module mpu_dac_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mpu_dac_pkg::M_TDATA_W-1:0] m_tdata
);
    import mpu_dac_pkg::*;

    // a stalled result word holds
    `MPU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // only the three verdict codes ever leave the block
    `MPU_ASSERT_IMPLY(a_verdict_code, aclk, aresetn, m_tvalid, m_tdata[VERD_W-1:0] == VERDICT_DONE || m_tdata[VERD_W-1:0] == VERDICT_PERMIT || m_tdata[VERD_W-1:0] == VERDICT_DENY, "illegal verdict code")

    // with the sink ready the pipeline never blocks the source
    `MPU_ASSERT_IMPLY(a_no_bubble, aclk, aresetn, m_tready, s_tready, "input stalled with sink ready")

    // reset empties the result register
    `MPU_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid, "result valid straight after reset")

endmodule

bind mpu_data_access_checker_top mpu_dac_checker u_mpu_dac_checker (.*);
